// ----- rtl/rrt_tree_extend_step_defines.svh -----
// Assertion macros shared by the tree extension engine.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef RRT_TREE_EXTEND_STEP_DEFINES_SVH
`define RRT_TREE_EXTEND_STEP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rrt_pkg.sv -----
// Shared types, codes and sizes of the tree extension engine.
// No dependencies; the datapath, controller and top module import this package.
package rrt_pkg;

    // Store sizes.
    localparam int MAX_NODES = 1024;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_AW + 1;
    localparam int GRID_SIZE = 128;
    localparam int GRID_AW   = $clog2(GRID_SIZE);
    localparam int MAP_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int MAP_AW    = 2 * GRID_AW;
    localparam logic [GRID_AW:0] GRID_LIM = (GRID_AW + 1)'(GRID_SIZE);

    // Coordinate and arithmetic widths.
    localparam int COORD_W    = 15;
    localparam int POS_W      = 2 * COORD_W;
    localparam int DIST2_W    = 2 * COORD_W + 1;
    localparam int SQRT_STEPS = (DIST2_W + 1) / 2;
    localparam int NUM_W      = COORD_W + 7;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 2;

    // Actions.
    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_EXTEND  = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    // Result status codes.
    localparam logic [2:0] STS_ADDED   = 3'd0;
    localparam logic [2:0] STS_BLOCKED = 3'd1;
    localparam logic [2:0] STS_FULL    = 3'd2;
    localparam logic [2:0] STS_NOTREE  = 3'd3;
    localparam logic [2:0] STS_ACK     = 3'd4;
    localparam logic [2:0] STS_NODE    = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_LIMIT = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [6:0]         cell_x;
        logic [6:0]         cell_y;
        logic               cell_blocked;
        logic [COORD_W-1:0] sample_x;
        logic [COORD_W-1:0] sample_y;
        logic [9:0]         node_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [9:0]         result_index;
        logic [9:0]         parent_index;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               is_root;
    } out_item_t;

    typedef enum logic [2:0] {
        RES_ACK,
        RES_NODE,
        RES_ADDED,
        RES_BLOCKED,
        RES_FULL,
        RES_NOTREE
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     cap;
        logic     cell_wr;
        logic     root_wr;
        logic     rd_issue;
        logic     rd_capture;
        logic     scan_start;
        logic     scan_run;
        logic     sqrt_start;
        logic     sqrt_step;
        logic     div_load;
        logic     div_axis;
        logic     div_step;
        logic     div_save;
        logic     walk_init;
        logic     walk_step;
        logic     chk_eval;
        logic     map_step;
        logic     append;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       clr_done;
        logic       count_zero;
        logic       count_full;
        logic       best_zero;
        logic       scan_done;
        logic       sqrt_done;
        logic       div_done;
        logic       chk_bad;
        logic       map_done;
        logic       map_hit;
        logic       k_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- rtl/rrt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/rrt_datapath.sv -----
// Datapath: configuration, map and node stores, nearest-node scan, square root,
// divider, segment walk and the output register. Depends on rrt_pkg and rrt_ram.
`include "rrt_tree_extend_step_defines.svh"

module rrt_datapath
    import rrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration and control registers.
    logic [COORD_W-1:0] start_x_reg, start_y_reg;
    logic [6:0]         step_size_reg;
    logic [7:0]         map_limit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [MAP_AW:0]    clr_cnt_reg;
    logic               out_valid_reg;
    logic [CNT_W-1:0]   scan_ai_reg;
    logic               v1_reg, v2_reg, best_valid_reg;
    logic [4:0]         sqrt_cnt_reg, div_cnt_reg;
    logic [2:0]         sub_reg;
    logic [7:0]         k_reg;

    // Payload registers.
    in_item_t           item_reg;
    out_item_t          out_reg;
    logic [NODE_AW-1:0] idx1_reg, idx2_reg, best_reg;
    logic [COORD_W-1:0] x2_reg, y2_reg, near_x_reg, near_y_reg;
    logic [POS_W-1:0]   sqx_reg, sqy_reg;
    logic [DIST2_W-1:0] bestd_reg;
    logic [31:0]        sq_v_reg, sq_r_reg, sq_b_reg;
    logic [15:0]        dist_reg;
    logic [NUM_W-1:0]   num_reg, quo_reg;
    logic [16:0]        rem_reg;
    logic               axis_reg;
    logic [7:0]         q0x_reg, q0y_reg;
    logic [15:0]        r0x_reg, r0y_reg;
    logic [15:0]        qx_reg, qy_reg;
    logic [16:0]        rx_reg, ry_reg;
    logic [GRID_AW-1:0] fx_reg, fy_reg, cx_reg, cy_reg;
    logic [COORD_W-1:0] ptx_reg, pty_reg;
    logic               hit_reg;
    logic [NODE_AW-1:0] rd_par_reg;
    logic [POS_W-1:0]   rd_pos_reg;

    // Memory ports.
    logic               map_we, map_wdata, map_rdata;
    logic [MAP_AW-1:0]  map_waddr, map_raddr;
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr, node_raddr, par_wdata, par_rdata;
    logic [POS_W-1:0]   pos_wdata, pos_rdata;

    logic               clr_active, scan_issue;
    logic [15:0]        dxs, dys;
    logic signed [31:0] prodx, prody;
    logic [DIST2_W-1:0] dsum;
    logic [15:0]        dxb, dyb;
    logic               negx, negy;
    logic [COORD_W-1:0] magx, magy;
    logic [31:0]        sq_rb;
    logic [16:0]        div_t;
    logic [16:0]        rsx, rsy;
    logic [17:0]        px_w, py_w;
    logic [15:0]        cx_w, cy_w;
    logic [7:0]         cxf, cyf;
    logic               badx, bady;
    logic [CNT_W-1:0]   cnt_m1;

    assign clr_active = (clr_cnt_reg != (MAP_AW + 1)'(MAP_DEPTH));
    assign scan_issue = cmd.scan_run && (scan_ai_reg != count_reg);

    // Map store: clearing pass, cell writes and the four-corner reads.
    assign map_we    = clr_active || cmd.cell_wr;
    assign map_waddr = clr_active ? clr_cnt_reg[MAP_AW-1:0]
                                  : {item_reg.cell_x, item_reg.cell_y};
    assign map_wdata = clr_active ? 1'b0 : item_reg.cell_blocked;

    always_comb
    begin
        unique case (sub_reg)
            3'd0:    map_raddr = {fx_reg, fy_reg};
            3'd1:    map_raddr = {fx_reg, cy_reg};
            3'd2:    map_raddr = {cx_reg, fy_reg};
            default: map_raddr = {cx_reg, cy_reg};
        endcase
    end

    rrt_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Node stores: root and append writes, scan and read-back reads.
    assign node_we    = cmd.root_wr || cmd.append;
    assign node_waddr = cmd.append ? count_reg[NODE_AW-1:0] : '0;
    assign pos_wdata  = cmd.append ? {ptx_reg, pty_reg} : {start_x_reg, start_y_reg};
    assign par_wdata  = cmd.append ? best_reg : '0;
    assign node_raddr = cmd.rd_issue ? item_reg.node_index : scan_ai_reg[NODE_AW-1:0];

    rrt_ram #(.WIDTH(POS_W), .DEPTH(MAX_NODES)) u_pos (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (pos_wdata),
        .raddr (node_raddr),
        .rdata (pos_rdata)
    );

    rrt_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_par (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (par_wdata),
        .raddr (node_raddr),
        .rdata (par_rdata)
    );

    // Scan stage one: differences and squares of the node just read.
    assign dxs   = {1'b0, item_reg.sample_x} - {1'b0, pos_rdata[POS_W-1:COORD_W]};
    assign dys   = {1'b0, item_reg.sample_y} - {1'b0, pos_rdata[COORD_W-1:0]};
    assign prodx = $signed(dxs) * $signed(dxs);
    assign prody = $signed(dys) * $signed(dys);
    // Scan stage two: squared distance.
    assign dsum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Direction from the nearest node to the sample.
    assign dxb  = {1'b0, item_reg.sample_x} - {1'b0, near_x_reg};
    assign dyb  = {1'b0, item_reg.sample_y} - {1'b0, near_y_reg};
    assign negx = dxb[15];
    assign negy = dyb[15];
    assign magx = negx ? COORD_W'(~dxb + 16'd1) : dxb[COORD_W-1:0];
    assign magy = negy ? COORD_W'(~dyb + 16'd1) : dyb[COORD_W-1:0];

    // One square root step and one divider step.
    assign sq_rb = sq_r_reg + sq_b_reg;
    assign div_t = {rem_reg[15:0], num_reg[NUM_W-1]};

    // Next remainders of the running quotients along the segment.
    assign rsx = rx_reg + {1'b0, r0x_reg};
    assign rsy = ry_reg + {1'b0, r0y_reg};

    // Check point and its cell bounds.
    assign px_w = {3'b0, near_x_reg} + (negx ? (~{2'b0, qx_reg} + 18'd1) : {2'b0, qx_reg});
    assign py_w = {3'b0, near_y_reg} + (negy ? (~{2'b0, qy_reg} + 18'd1) : {2'b0, qy_reg});
    assign cx_w = {1'b0, px_w[COORD_W-1:0]} + 16'd255;
    assign cy_w = {1'b0, py_w[COORD_W-1:0]} + 16'd255;
    assign cxf  = cx_w[15:8];
    assign cyf  = cy_w[15:8];
    assign badx = px_w[17] || (px_w[16:15] != 2'b0) || (px_w[14:8] == 7'd0)
               || (cxf >= map_limit_reg) || (cxf >= GRID_LIM);
    assign bady = py_w[17] || (py_w[16:15] != 2'b0) || (py_w[14:8] == 7'd0)
               || (cyf >= map_limit_reg) || (cyf >= GRID_LIM);

    assign cnt_m1 = count_reg - CNT_W'(1);

    // Status toward the controller.
    always_comb
    begin
        stat.action     = item_reg.action;
        stat.clr_done   = !clr_active;
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == CNT_W'(MAX_NODES));
        stat.best_zero  = (bestd_reg == '0);
        stat.scan_done  = (scan_ai_reg == count_reg) && !v1_reg && !v2_reg;
        stat.sqrt_done  = (sqrt_cnt_reg == 5'(SQRT_STEPS));
        stat.div_done   = (div_cnt_reg == 5'(DIV_STEPS));
        stat.chk_bad    = badx || bady;
        stat.map_done   = (sub_reg == 3'd4);
        stat.map_hit    = hit_reg || map_rdata;
        stat.k_last     = (k_reg == {step_size_reg, 1'b0});
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            step_size_reg  <= 7'd4;
            map_limit_reg  <= 8'd100;
            count_reg      <= '0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            scan_ai_reg    <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
            sqrt_cnt_reg   <= '0;
            div_cnt_reg    <= '0;
            sub_reg        <= '0;
            k_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_START_X:   start_x_reg   <= cfg_data;
                    REG_START_Y:   start_y_reg   <= cfg_data;
                    REG_STEP_SIZE: step_size_reg <= cfg_data[6:0];
                    REG_MAP_LIMIT: map_limit_reg <= cfg_data[7:0];
                    default:       start_x_reg   <= start_x_reg;
                endcase
            end
            if (clr_active)
            begin
                clr_cnt_reg <= clr_cnt_reg + (MAP_AW + 1)'(1);
            end
            priority if (cmd.root_wr)
            begin
                count_reg <= CNT_W'(1);
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            priority if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // Scan pipeline control.
            v1_reg <= scan_issue;
            v2_reg <= v1_reg;
            priority if (cmd.scan_start)
            begin
                scan_ai_reg    <= '0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    scan_ai_reg <= scan_ai_reg + CNT_W'(1);
                end
                if (v2_reg)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
            priority if (cmd.sqrt_start)
            begin
                sqrt_cnt_reg <= '0;
            end
            else if (cmd.sqrt_step)
            begin
                sqrt_cnt_reg <= sqrt_cnt_reg + 5'd1;
            end
            priority if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            priority if (cmd.chk_eval)
            begin
                sub_reg <= '0;
            end
            else if (cmd.map_step)
            begin
                sub_reg <= sub_reg + 3'd1;
            end
            priority if (cmd.walk_init)
            begin
                k_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                k_reg <= k_reg + 8'd1;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            item_reg <= in_data;
        end
        if (cmd.rd_capture)
        begin
            rd_pos_reg <= pos_rdata;
            rd_par_reg <= par_rdata;
        end
        // Scan: carry index and position down the pipeline, keep the first minimum.
        idx1_reg <= scan_ai_reg[NODE_AW-1:0];
        idx2_reg <= idx1_reg;
        x2_reg   <= pos_rdata[POS_W-1:COORD_W];
        y2_reg   <= pos_rdata[COORD_W-1:0];
        sqx_reg  <= prodx[POS_W-1:0];
        sqy_reg  <= prody[POS_W-1:0];
        if (v2_reg && (!best_valid_reg || (dsum < bestd_reg)))
        begin
            bestd_reg  <= dsum;
            best_reg   <= idx2_reg;
            near_x_reg <= x2_reg;
            near_y_reg <= y2_reg;
        end
        // Integer square root, two bits of the radicand a step.
        priority if (cmd.sqrt_start)
        begin
            sq_v_reg <= {1'b0, bestd_reg};
            sq_r_reg <= '0;
            sq_b_reg <= 32'h4000_0000;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_v_reg >= sq_rb)
            begin
                sq_v_reg <= sq_v_reg - sq_rb;
                sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_b_reg <= sq_b_reg >> 2;
        end
        if (cmd.sqrt_step)
        begin
            dist_reg <= 16'((sq_v_reg >= sq_rb) ? ((sq_r_reg >> 1) + sq_b_reg)
                                                : (sq_r_reg >> 1));
        end
        // Restoring divider: 128 * magnitude over the distance, one bit a step.
        if (cmd.div_save)
        begin
            if (axis_reg)
            begin
                q0y_reg <= quo_reg[7:0];
                r0y_reg <= rem_reg[15:0];
            end
            else
            begin
                q0x_reg <= quo_reg[7:0];
                r0x_reg <= rem_reg[15:0];
            end
        end
        priority if (cmd.div_load)
        begin
            axis_reg <= cmd.div_axis;
            num_reg  <= cmd.div_axis ? {magy, 7'b0} : {magx, 7'b0};
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (div_t >= {1'b0, dist_reg})
            begin
                rem_reg <= div_t - {1'b0, dist_reg};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_t;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        // Running rounded offsets along the segment, one check point a step.
        priority if (cmd.walk_init)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            rx_reg <= {2'b0, dist_reg[15:1]};
            ry_reg <= {2'b0, dist_reg[15:1]};
        end
        else if (cmd.walk_step)
        begin
            if (rsx >= {1'b0, dist_reg})
            begin
                rx_reg <= rsx - {1'b0, dist_reg};
                qx_reg <= qx_reg + {8'b0, q0x_reg} + 16'd1;
            end
            else
            begin
                rx_reg <= rsx;
                qx_reg <= qx_reg + {8'b0, q0x_reg};
            end
            if (rsy >= {1'b0, dist_reg})
            begin
                ry_reg <= rsy - {1'b0, dist_reg};
                qy_reg <= qy_reg + {8'b0, q0y_reg} + 16'd1;
            end
            else
            begin
                ry_reg <= rsy;
                qy_reg <= qy_reg + {8'b0, q0y_reg};
            end
        end
        // Latch the check point and collect the four cell reads.
        if (cmd.chk_eval)
        begin
            ptx_reg <= px_w[COORD_W-1:0];
            pty_reg <= py_w[COORD_W-1:0];
            fx_reg  <= px_w[14:8];
            fy_reg  <= py_w[14:8];
            cx_reg  <= cxf[GRID_AW-1:0];
            cy_reg  <= cyf[GRID_AW-1:0];
            hit_reg <= 1'b0;
        end
        else if (cmd.map_step && (sub_reg != 3'd0))
        begin
            hit_reg <= hit_reg || map_rdata;
        end
        // Result register.
        if (cmd.res_load)
        begin
            out_reg <= '0;
            unique case (cmd.res_sel)
                RES_ACK:     out_reg.status <= STS_ACK;
                RES_BLOCKED: out_reg.status <= STS_BLOCKED;
                RES_FULL:    out_reg.status <= STS_FULL;
                RES_NOTREE:  out_reg.status <= STS_NOTREE;
                RES_NODE:
                begin
                    out_reg.status       <= STS_NODE;
                    out_reg.result_index <= item_reg.node_index;
                    out_reg.parent_index <= rd_par_reg;
                    out_reg.point_x      <= rd_pos_reg[POS_W-1:COORD_W];
                    out_reg.point_y      <= rd_pos_reg[COORD_W-1:0];
                    out_reg.is_root      <= (item_reg.node_index == '0);
                end
                RES_ADDED:
                begin
                    out_reg.status       <= STS_ADDED;
                    out_reg.result_index <= cnt_m1[NODE_AW-1:0];
                    out_reg.parent_index <= best_reg;
                    out_reg.point_x      <= ptx_reg;
                    out_reg.point_y      <= pty_reg;
                end
                default:     out_reg.status <= STS_ACK;
            endcase
        end
    end

    // Checks on the store and result handling.
    `RRT_ASSERT_SAME(a_append_room, cmd.append, count_reg < CNT_W'(MAX_NODES), "append into a full tree")
    `RRT_ASSERT_SAME(a_no_overwrite, cmd.res_load, !out_valid_reg || !out_stall, "result overwritten")
    `RRT_ASSERT_NEXT(a_load_shows, cmd.res_load, out_valid_reg, "loaded result not offered")
    `RRT_ASSERT_SAME(a_scan_best, cmd.scan_run && stat.scan_done, best_valid_reg, "scan ended without a node")

endmodule

// ----- rtl/rrt_ctrl.sv -----
// Controller state machine of the tree extension engine.
// Depends on rrt_pkg; drives the datapath through ctrl_cmd_t.
module rrt_ctrl
    import rrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_CLEAR    = 12'b0000_0000_0001,
        ST_IDLE     = 12'b0000_0000_0010,
        ST_DISPATCH = 12'b0000_0000_0100,
        ST_RD_WAIT  = 12'b0000_0000_1000,
        ST_SCAN     = 12'b0000_0001_0000,
        ST_SQRT     = 12'b0000_0010_0000,
        ST_DIV_X    = 12'b0000_0100_0000,
        ST_DIV_Y    = 12'b0000_1000_0000,
        ST_WALK_CHK = 12'b0001_0000_0000,
        ST_WALK_MAP = 12'b0010_0000_0000,
        ST_APPEND   = 12'b0100_0000_0000,
        ST_FINISH   = 12'b1000_0000_0000
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.action)
                    ACT_WRITE:
                    begin
                        cmd.cell_wr  = 1'b1;
                        res_sel_next = RES_ACK;
                        state_next   = ST_FINISH;
                    end
                    ACT_RESTART:
                    begin
                        cmd.root_wr  = 1'b1;
                        res_sel_next = RES_ACK;
                        state_next   = ST_FINISH;
                    end
                    ACT_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_RD_WAIT;
                    end
                    default:
                    begin
                        priority if (stat.count_zero)
                        begin
                            res_sel_next = RES_NOTREE;
                            state_next   = ST_FINISH;
                        end
                        else if (stat.count_full)
                        begin
                            res_sel_next = RES_FULL;
                            state_next   = ST_FINISH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                cmd.rd_capture = 1'b1;
                res_sel_next   = RES_NODE;
                state_next     = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.best_zero)
                    begin
                        res_sel_next = RES_BLOCKED;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        cmd.sqrt_start = 1'b1;
                        state_next     = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (!stat.sqrt_done)
                begin
                    cmd.sqrt_step = 1'b1;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_axis = 1'b0;
                    state_next   = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (!stat.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cmd.div_save = 1'b1;
                    cmd.div_load = 1'b1;
                    cmd.div_axis = 1'b1;
                    state_next   = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (!stat.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cmd.div_save  = 1'b1;
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK:
            begin
                cmd.chk_eval = 1'b1;
                if (stat.chk_bad)
                begin
                    res_sel_next = RES_BLOCKED;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WALK_MAP;
                end
            end
            ST_WALK_MAP:
            begin
                cmd.map_step = 1'b1;
                if (stat.map_done)
                begin
                    priority if (stat.map_hit)
                    begin
                        res_sel_next = RES_BLOCKED;
                        state_next   = ST_FINISH;
                    end
                    else if (stat.k_last)
                    begin
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        cmd.walk_step = 1'b1;
                        state_next    = ST_WALK_CHK;
                    end
                end
            end
            ST_APPEND:
            begin
                cmd.append   = 1'b1;
                res_sel_next = RES_ADDED;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.res_sel = res_sel_reg;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            res_sel_reg <= RES_ACK;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

endmodule

// ----- rtl/rrt_tree_extend_step.sv -----
// Extend time grows with the tree size and the step size, set by the one-node-a-cycle scan
// of the node store and the one-read-a-cycle map port (four reads per check point).
// One item is in work at a time; a finished result waits in the output register.
// Reset: asynchronous, active low; afterwards a clearing pass writes all 16384 map cells
// to zero, during which no item is taken. Configuration writes are taken at any time.
module rrt_tree_extend_step
    import rrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer.
    rrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stores and arithmetic.
    rrt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
